>>> rtl/usd_pkg.sv
// Shared types and constants for the ustar stream deframer.
`default_nettype none
package usd_pkg;
    localparam int unsigned BlockBytes = 512;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_TRUNCATED   = 2'd1,
        ERR_UNSAFE      = 2'd2,
        ERR_UNSUPPORTED = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

    // One result transaction
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  entry_class;
        logic [7:0]  type_byte;
        logic [35:0] entry_size;
        logic [11:0] perm_bits;
        logic [23:0] owner_id;
        logic [23:0] group_id;
        logic [35:0] mod_time;
        logic [35:0] device_number;
        logic [7:0]  payload_byte;
        err_t        error_code;
        logic        path_unsafe;
    } result_t;

    // Octal digit accumulate; non-digits leave the value unchanged
    function automatic logic [35:0] oct36(input logic [35:0] acc, input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h37) oct36 = {acc[32:0], b[2:0]};
        else oct36 = acc;
    endfunction

    function automatic logic [23:0] oct24(input logic [23:0] acc, input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h37) oct24 = {acc[20:0], b[2:0]};
        else oct24 = acc;
    endfunction

    function automatic logic [2:0] class_of(input logic [7:0] t);
        case (t)
            8'h30, 8'h00, 8'h37: class_of = 3'd0;
            8'h31: class_of = 3'd1;
            8'h32: class_of = 3'd2;
            8'h33: class_of = 3'd3;
            8'h34: class_of = 3'd4;
            8'h35: class_of = 3'd5;
            8'h36: class_of = 3'd6;
            default: class_of = 3'd7;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> rtl/usd_core.sv
// Per-byte header parsing, data skipping and result generation.
`default_nettype none
module usd_core
    import usd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       extract_mode,
    input  wire logic       step,
    input  wire logic [7:0] b,
    input  wire logic       stream_end,
    output logic            res_valid,
    output result_t         res
);
    phase_t      phase_reg, phase_next;
    logic [8:0]  off_reg, off_next;
    logic [36:0] left_reg, left_next;
    logic [35:0] pay_reg, pay_next;
    logic        emit_reg, emit_next;
    logic [35:0] size_reg, size_next, mtime_reg, mtime_next;
    logic [23:0] mode_reg, mode_next, uid_reg, uid_next, gid_reg, gid_next;
    logic [23:0] maj_reg, maj_next, min_reg, min_next;
    logic [7:0]  type_reg, type_next;
    logic        nz_reg, nz_next;
    logic [1:0]  empty_reg, empty_next;
    // path scan: st, ended, dotdot, name_abs, pfx_nonempty, pfx_abs
    logic [1:0]  st_reg, st_next;
    logic        ended_reg, ended_next, dd_reg, dd_next;
    logic        nabs_reg, nabs_next, pne_reg, pne_next, pabs_reg, pabs_next;

    always_comb begin
        logic [1:0]  st;
        logic        ended, dd, unsafe, fin, scan_on, last;
        logic [2:0]  cls;
        logic [23:0] mode;
        logic [35:0] blocks;
        phase_next = phase_reg; off_next = off_reg; left_next = left_reg;
        pay_next = pay_reg; emit_next = emit_reg;
        size_next = size_reg; mtime_next = mtime_reg; mode_next = mode_reg;
        uid_next = uid_reg; gid_next = gid_reg; maj_next = maj_reg; min_next = min_reg;
        type_next = type_reg; nz_next = nz_reg; empty_next = empty_reg;
        st_next = st_reg; ended_next = ended_reg; dd_next = dd_reg;
        nabs_next = nabs_reg; pne_next = pne_reg; pabs_next = pabs_reg;
        res_valid = 1'b0;
        res = '0;
        st = st_reg; ended = ended_reg; dd = dd_reg;
        scan_on = 1'b0; last = 1'b0; fin = 1'b0;
        cls = class_of(type_reg);
        mode = mode_reg;
        blocks = '0; unsafe = 1'b0;

        if (step && phase_reg == PH_DATA) begin
            if (stream_end) begin
                phase_next = PH_STOP;
                res_valid = 1'b1;
                res.kind = emit_reg ? KIND_ERROR : KIND_END;
                res.error_code = emit_reg ? ERR_TRUNCATED : ERR_NONE;
            end else begin
                if (emit_reg && pay_reg != '0) begin
                    res_valid = 1'b1;
                    res.kind = KIND_DATA;
                    res.payload_byte = b;
                    pay_next = pay_reg - 36'd1;
                end
                if (left_reg <= 37'd1) begin
                    left_next = '0;
                    phase_next = PH_HEADER;
                    emit_next = 1'b0;
                    pay_next = '0;
                end else begin
                    left_next = left_reg - 37'd1;
                end
            end
        end else if (step && phase_reg == PH_HEADER) begin
            if (stream_end) begin
                phase_next = PH_STOP;
                res_valid = 1'b1;
                res.kind = (off_reg == '0) ? KIND_END : KIND_ERROR;
                res.error_code = (off_reg == '0) ? ERR_NONE : ERR_TRUNCATED;
            end else begin
                if (b != 8'h00) nz_next = 1'b1;
                // field absorb by block offset
                if (off_reg < 9'd100) begin
                    if (off_reg == 9'd0 && b == 8'h2f) nabs_next = 1'b1;
                    scan_on = 1'b1; last = (off_reg == 9'd99);
                end else if (off_reg < 9'd108) mode_next = oct24(mode_reg, b);
                else if (off_reg < 9'd116) uid_next = oct24(uid_reg, b);
                else if (off_reg < 9'd124) gid_next = oct24(gid_reg, b);
                else if (off_reg < 9'd136) size_next = oct36(size_reg, b);
                else if (off_reg < 9'd148) mtime_next = oct36(mtime_reg, b);
                else if (off_reg == 9'd156) type_next = b;
                else if (off_reg >= 9'd329 && off_reg < 9'd337) maj_next = oct24(maj_reg, b);
                else if (off_reg >= 9'd337 && off_reg < 9'd345) min_next = oct24(min_reg, b);
                else if (off_reg >= 9'd345 && off_reg < 9'd500) begin
                    if (off_reg == 9'd345) begin
                        st = 2'd0; ended = 1'b0;
                        if (b != 8'h00) pne_next = 1'b1;
                        if (b == 8'h2f) pabs_next = 1'b1;
                    end
                    scan_on = 1'b1; last = (off_reg == 9'd499);
                end
                // path component scanner
                if (scan_on && !ended) begin
                    if (b == 8'h00) begin
                        if (st == 2'd2) dd = 1'b1;
                        ended = 1'b1;
                    end else begin
                        if (b == 8'h2f) begin
                            if (st == 2'd2) dd = 1'b1;
                            st = 2'd0;
                        end else if (b == 8'h2e) begin
                            st = (st == 2'd0) ? 2'd1 : ((st == 2'd1) ? 2'd2 : 2'd3);
                        end else st = 2'd3;
                        if (last && st == 2'd2) dd = 1'b1;
                    end
                end
                st_next = st; ended_next = ended; dd_next = dd;
                off_next = off_reg + 9'd1;
                fin = (off_reg == 9'(BlockBytes - 1));
            end
        end

        // end of header block
        if (fin) begin
            off_next = '0;
            if (!nz_next) begin
                empty_next = (empty_reg < 2'd2) ? empty_reg + 2'd1 : empty_reg;
                if (empty_reg >= 2'd1) begin
                    phase_next = PH_STOP;
                    res_valid = 1'b1;
                    res.kind = KIND_END;
                end
            end else begin
                empty_next = '0;
                cls = class_of(type_next);
                mode = mode_next;
                if (mode == '0) mode = (type_next == 8'h35) ? 24'o755 : 24'o644;
                unsafe = pne_next ? (pabs_next | dd_next) : (nabs_next | dd_next);
                res_valid = 1'b1;
                res.kind = KIND_HEADER;
                res.entry_class = cls;
                res.type_byte = type_next;
                res.entry_size = size_next;
                res.perm_bits = mode[11:0];
                res.owner_id = uid_next;
                res.group_id = gid_next;
                res.mod_time = mtime_next;
                if (cls == 3'd3 || cls == 3'd4 || cls == 3'd6)
                    res.device_number = {min_next[23:8], maj_next[11:0], min_next[7:0]};
                res.path_unsafe = unsafe;
                if (extract_mode && (unsafe || cls == 3'd7)) begin
                    res.kind = KIND_ERROR;
                    res.error_code = unsafe ? ERR_UNSAFE : ERR_UNSUPPORTED;
                    phase_next = PH_STOP;
                end else begin
                    blocks = {size_next[35:9], 9'd0};
                    if (size_next[8:0] != '0) blocks = blocks + 36'd512;
                    if (size_next != '0) begin
                        phase_next = PH_DATA;
                        left_next = (size_next[8:0] != '0 && size_next[35:9] == '1)
                            ? 37'h1000000000 : {1'b0, blocks};
                        emit_next = extract_mode && cls == 3'd0;
                        pay_next = (extract_mode && cls == 3'd0) ? size_next : '0;
                    end
                end
            end
            size_next = '0; mtime_next = '0; mode_next = '0; uid_next = '0;
            gid_next = '0; maj_next = '0; min_next = '0; type_next = '0;
            nz_next = 1'b0; st_next = '0; ended_next = 1'b0; dd_next = 1'b0;
            nabs_next = 1'b0; pne_next = 1'b0; pabs_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER; off_reg <= '0; left_reg <= '0; pay_reg <= '0;
            emit_reg <= 1'b0; size_reg <= '0; mtime_reg <= '0; mode_reg <= '0;
            uid_reg <= '0; gid_reg <= '0; maj_reg <= '0; min_reg <= '0;
            type_reg <= '0; nz_reg <= 1'b0; empty_reg <= '0; st_reg <= '0;
            ended_reg <= 1'b0; dd_reg <= 1'b0; nabs_reg <= 1'b0;
            pne_reg <= 1'b0; pabs_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; off_reg <= off_next; left_reg <= left_next;
            pay_reg <= pay_next; emit_reg <= emit_next; size_reg <= size_next;
            mtime_reg <= mtime_next; mode_reg <= mode_next; uid_reg <= uid_next;
            gid_reg <= gid_next; maj_reg <= maj_next; min_reg <= min_next;
            type_reg <= type_next; nz_reg <= nz_next; empty_reg <= empty_next;
            st_reg <= st_next; ended_reg <= ended_next; dd_reg <= dd_next;
            nabs_reg <= nabs_next; pne_reg <= pne_next; pabs_reg <= pabs_next;
        end
    end

    // once stopped, nothing more comes out
    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOP |-> !res_valid) else $error("result after stop");
    a_data_off: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> off_reg == '0) else $error("offset moved in data");
    a_emit_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> !emit_reg && pay_reg == '0) else $error("stale payload");
endmodule
`default_nettype wire

>>> rtl/usd_out_reg.sv
// Output register with skid stage for the result channel.
`default_nettype none
module usd_out_reg
    import usd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  result_t   in_data,
    output logic      in_ready,
    output logic      out_valid,
    output result_t   out_data,
    input  wire logic out_ready
);
    logic    main_v_reg, skid_v_reg;
    result_t main_reg, skid_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0; skid_v_reg <= 1'b0;
        end else begin
            if (!main_v_reg || out_ready) begin
                main_v_reg <= skid_v_reg || in_valid;
                skid_v_reg <= 1'b0;
            end else if (in_valid && in_ready) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_v_reg || out_ready) main_reg <= skid_v_reg ? skid_reg : in_data;
        if (in_valid && in_ready) skid_reg <= in_data;
    end
endmodule
`default_nettype wire

>>> rtl/ustar_stream_deframer_core.sv
// Top level of the ustar stream deframer.
// Takes one archive byte per cycle in any state while s_ready is high; a header report, data byte or stop
// result leaves through a two-entry output register, so the byte rate is one per cycle
// while m_ready keeps up. Input ready falls only when both output entries are full.
`default_nettype none
module ustar_stream_deframer_core
    import usd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_archive_byte,
    input  wire logic        s_stream_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [2:0]       m_entry_class,
    output logic [7:0]       m_type_byte,
    output logic [35:0]      m_entry_size,
    output logic [11:0]      m_perm_bits,
    output logic [23:0]      m_owner_id,
    output logic [23:0]      m_group_id,
    output logic [35:0]      m_mod_time,
    output logic [35:0]      m_device_number,
    output logic [7:0]       m_payload_byte,
    output logic [1:0]       m_error_code,
    output logic             m_path_unsafe
);
    logic    extract_reg, rv;
    result_t r, q;

    always_ff @(posedge aclk) begin
        if (!aresetn) extract_reg <= 1'b0;
        else if (cfg_we) extract_reg <= cfg_wdata;
    end

    usd_core u_core (.aclk, .aresetn, .extract_mode(extract_reg),
        .step(s_valid && s_ready), .b(s_archive_byte), .stream_end(s_stream_end),
        .res_valid(rv), .res(r));

    usd_out_reg u_out (.aclk, .aresetn, .in_valid(rv), .in_data(r), .in_ready(s_ready),
        .out_valid(m_valid), .out_data(q), .out_ready(m_ready));

    assign m_kind = q.kind;
    assign m_entry_class = q.entry_class;
    assign m_type_byte = q.type_byte;
    assign m_entry_size = q.entry_size;
    assign m_perm_bits = q.perm_bits;
    assign m_owner_id = q.owner_id;
    assign m_group_id = q.group_id;
    assign m_mod_time = q.mod_time;
    assign m_device_number = q.device_number;
    assign m_payload_byte = q.payload_byte;
    assign m_error_code = q.error_code;
    assign m_path_unsafe = q.path_unsafe;
endmodule
`default_nettype wire
